### rtl/rcs_pkg.sv
// package: sizes, codes and item types shared by the range count store
`timescale 1ns / 1ps
package rcs_pkg;

  localparam int DEPTH   = 1024;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 12;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // running sum spans -DEPTH..DEPTH, and is never narrower than the result field
  localparam int ACC_W   = (CNT_W + 1 > COUNT_W) ? CNT_W + 1 : COUNT_W;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_QUERY   = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // value store write, broadcast to every cell
  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] data;
  } rcs_wr_t;

  // one item as it travels down the cell chain
  typedef struct packed {
    logic                    is_query;
    logic                    status;
    logic signed [VAL_W-1:0] low_bound;
    logic signed [VAL_W-1:0] high_bound;
    logic [CNT_W-1:0]        n;
    logic signed [ACC_W-1:0] acc;
  } rcs_stage_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic                      status;
  } rcs_result_t;

endpackage

### rtl/rcs_if.sv
// interfaces: input item channel and result channel
`timescale 1ns / 1ps
interface rcs_in_if
  import rcs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] low_bound;
  logic signed [VAL_W-1:0] high_bound;

  modport source (output valid, output command, output value, output low_bound,
                  output high_bound, input ready);
  modport sink   (input valid, input command, input value, input low_bound,
                  input high_bound, output ready);
endinterface

interface rcs_out_if
  import rcs_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] count;
  logic                      status;

  modport source (output valid, output count, output status, input ready);
  modport sink   (input valid, input count, input status, output ready);
endinterface

### rtl/range_count_store_top.sv
// top level: range count store built as a chain of value cells
//
//   channel  dir  handshake       payload
//   in_ch    in   valid / ready   command, value, low_bound, high_bound
//   out_ch   out  valid / ready   count, status
//
// one item enters per cycle while the result buffer has room; its result leaves
// after passing every cell of the chain once and the result buffer, in the order
// the items came in. a load writes its cell at acceptance unless the store is full;
// each query carries the fill count it saw, so later loads never change its answer.
// the chain stops only when the two-entry result buffer is full.
// synchronous active-low reset empties the store, the chain and the buffer.
`timescale 1ns / 1ps
module range_count_store_top
  import rcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  rcs_in_if.sink     in_ch,
  rcs_out_if.source  out_ch
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (COUNT_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(2 ** (COUNT_W - 1)));

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             full;
  logic             accept;
  logic             adv;
  rcs_wr_t          wr;
  logic             chain_v [DEPTH+1];
  rcs_stage_t       chain_s [DEPTH+1];
  rcs_stage_t       last;
  rcs_result_t      result;
  rcs_result_t      out_data;
  logic             out_valid;

  assign full         = count_r == CNT_W'(DEPTH);
  assign in_ch.ready  = adv;
  assign accept       = in_ch.valid && adv;

  assign wr.en   = accept && in_ch.command == CMD_LOAD && !full;
  assign wr.idx  = count_r[IDX_W-1:0];
  assign wr.data = in_ch.value;

  always_comb begin
    count_nxt = count_r;
    if (wr.en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_comb begin
    chain_v[0]            = accept;
    chain_s[0].is_query   = in_ch.command == CMD_QUERY;
    chain_s[0].status     = (in_ch.command == CMD_LOAD && full) ? STATUS_FULL : STATUS_OK;
    chain_s[0].low_bound  = in_ch.low_bound;
    chain_s[0].high_bound = in_ch.high_bound;
    chain_s[0].n          = count_r;
    chain_s[0].acc        = '0;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rcs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .cell_idx   (IDX_W'(g)),
      .wr         (wr),
      .prev_valid (chain_v[g]),
      .prev       (chain_s[g]),
      .next_valid (chain_v[g+1]),
      .next       (chain_s[g+1])
    );
  end

  assign last = chain_s[DEPTH];

  // clamp the difference to the result field
  always_comb begin
    result.status = last.status;
    if (last.acc > SAT_MAX) begin
      result.count = SAT_MAX[COUNT_W-1:0];
    end else if (last.acc < SAT_MIN) begin
      result.count = SAT_MIN[COUNT_W-1:0];
    end else begin
      result.count = last.acc[COUNT_W-1:0];
    end
  end

  rcs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && chain_v[DEPTH]),
    .push_data (result),
    .space     (adv),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.valid  = out_valid;
  assign out_ch.count  = out_data.count;
  assign out_ch.status = out_data.status;

endmodule

### rtl/rcs_cell.sv
// chain cell: holds one stored value and adds its vote to each passing query
`timescale 1ns / 1ps
module rcs_cell
  import rcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [IDX_W-1:0] cell_idx,
  input  rcs_wr_t          wr,
  input  logic             prev_valid,
  input  rcs_stage_t       prev,
  output logic             next_valid,
  output rcs_stage_t       next
);

  logic signed [VAL_W-1:0] value_r;
  logic                    valid_r;
  rcs_stage_t              stage_r;
  rcs_stage_t              stage_nxt;
  logic                    occupied;
  logic                    le_hi;
  logic                    lt_lo;

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == cell_idx) begin
      value_r <= wr.data;
    end
  end

  // only cells written before the query entered take part
  assign occupied = CNT_W'(cell_idx) < prev.n;
  assign le_hi    = value_r <= prev.high_bound;
  assign lt_lo    = value_r < prev.low_bound;

  always_comb begin
    stage_nxt = prev;
    if (prev.is_query && occupied) begin
      stage_nxt.acc = prev.acc + ACC_W'(le_hi) - ACC_W'(lt_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign next_valid = valid_r;
  assign next       = stage_r;

endmodule

### rtl/rcs_out_buf.sv
// two-entry result buffer between the cell chain and the result channel
`timescale 1ns / 1ps
module rcs_out_buf
  import rcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rcs_result_t push_data,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output rcs_result_t out_data
);

  rcs_result_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  fill_r;
  logic [1:0]  fill_nxt;
  logic        pop;

  assign out_valid = fill_r != 2'd0;
  assign space     = fill_r != 2'd2;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

endmodule
